// ===== sv/hus_pkg.sv =====
// hus_pkg: types, codes and character constants shared by the url splitter
// used by hus_step, hus_obuf, http_url_splitter and hus_checker
`timescale 1ns / 1ps

package hus_pkg;

    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] part;
        logic       end_of_url;
        logic [2:0] status;
        logic       has_query;
    } t_res;

    typedef enum logic [1:0] {
        PH_SCHEME,
        PH_AUTH,
        PH_PATH,
        PH_QUERY
    } t_phase;

    typedef enum logic [2:0] {
        SM_NONE,
        SM_H,
        SM_HT,
        SM_HTT,
        SM_HTTP,
        SM_HTTPS,
        SM_COLON,
        SM_SLASH
    } t_smatch;

    typedef struct packed {
        t_phase      phase;
        t_smatch     scheme_match;
        logic        scheme_bad;
        logic [15:0] recent_bytes;
        logic        authority_nonempty;
        logic        at_in_authority;
        logic        hash_seen;
        logic        path_seen;
        logic        query_seen;
    } t_pstate;

    localparam t_pstate PSTATE_RESET = '{
        phase:              PH_SCHEME,
        scheme_match:       SM_NONE,
        scheme_bad:         1'b0,
        recent_bytes:       16'h0000,
        authority_nonempty: 1'b0,
        at_in_authority:    1'b0,
        hash_seen:          1'b0,
        path_seen:          1'b0,
        query_seen:         1'b0
    };

    localparam logic [2:0] PART_SCHEME = 3'd0;
    localparam logic [2:0] PART_SEP    = 3'd1;
    localparam logic [2:0] PART_AUTH   = 3'd2;
    localparam logic [2:0] PART_PATH   = 3'd3;
    localparam logic [2:0] PART_QUERY  = 3'd4;
    localparam logic [2:0] PART_END    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SCHEME = 3'd1;
    localparam logic [2:0] ST_BAD_SCHEME = 3'd2;
    localparam logic [2:0] ST_NO_AUTH   = 3'd3;
    localparam logic [2:0] ST_USER_INFO = 3'd4;
    localparam logic [2:0] ST_FRAGMENT  = 3'd5;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // ":/" as the last two scheme bytes
    localparam logic [15:0] RECENT_MARK = 16'h3A2F;

    function automatic t_res mk_res(input logic [7:0] b, input logic [2:0] p);
        t_res r;
        r            = '0;
        r.byte_out   = b;
        r.part       = p;
        return r;
    endfunction

endpackage

// ===== sv/hus_step.sv =====
// hus_step: per-byte parse logic, next state and up to three result beats
// depends on hus_pkg
`timescale 1ns / 1ps

module hus_step (
    input  hus_pkg::t_pstate                       i_st,
    input  hus_pkg::t_item                         i_item,
    output hus_pkg::t_pstate                       o_st,
    output hus_pkg::t_res [hus_pkg::RES_SLOTS-1:0] o_res,
    output logic [1:0]                             o_cnt
);
    import hus_pkg::*;

    t_pstate    st;
    t_pstate    st_fin;
    logic [7:0] b;
    logic [7:0] c;
    logic       is_sep;
    logic       ok;
    t_res       m0;
    t_res       m1;
    t_res       fin;
    logic       two;
    logic       slash;
    logic [2:0] stat;

    always_comb begin
        b      = i_item.byte_in;
        c      = (b >= CH_UC_A && b <= CH_UC_Z) ? (b | CASE_BIT) : b;
        is_sep = (b == CH_COLON) || (b == CH_SLASH);
        st     = i_st;
        ok     = 1'b0;
        m0     = '0;
        m1     = '0;
        two    = 1'b0;
        unique case (i_st.phase)
            PH_SCHEME: begin
                if (b == CH_SLASH && i_st.recent_bytes == RECENT_MARK) begin
                    if (i_st.scheme_match != SM_SLASH) begin
                        st.scheme_bad = 1'b1;
                    end
                    st.phase = PH_AUTH;
                    m0       = mk_res(b, PART_SEP);
                end else begin
                    unique case (i_st.scheme_match)
                        SM_NONE: begin
                            if (c == CH_H) begin
                                st.scheme_match = SM_H;
                                ok              = 1'b1;
                            end
                        end
                        SM_H: begin
                            if (c == CH_T) begin
                                st.scheme_match = SM_HT;
                                ok              = 1'b1;
                            end
                        end
                        SM_HT: begin
                            if (c == CH_T) begin
                                st.scheme_match = SM_HTT;
                                ok              = 1'b1;
                            end
                        end
                        SM_HTT: begin
                            if (c == CH_P) begin
                                st.scheme_match = SM_HTTP;
                                ok              = 1'b1;
                            end
                        end
                        SM_HTTP: begin
                            if (c == CH_S) begin
                                st.scheme_match = SM_HTTPS;
                                ok              = 1'b1;
                            end else if (c == CH_COLON) begin
                                st.scheme_match = SM_COLON;
                                ok              = 1'b1;
                            end
                        end
                        SM_HTTPS: begin
                            if (c == CH_COLON) begin
                                st.scheme_match = SM_COLON;
                                ok              = 1'b1;
                            end
                        end
                        SM_COLON: begin
                            if (c == CH_SLASH) begin
                                st.scheme_match = SM_SLASH;
                                ok              = 1'b1;
                            end
                        end
                        SM_SLASH: begin
                            ok = 1'b0;
                        end
                    endcase
                    // once bad, the matcher freezes
                    if (i_st.scheme_bad) begin
                        st.scheme_match = i_st.scheme_match;
                    end else if (!ok) begin
                        st.scheme_bad = 1'b1;
                    end
                    st.recent_bytes = {i_st.recent_bytes[7:0], b};
                    m0 = is_sep ? mk_res(b, PART_SEP) : mk_res(c, PART_SCHEME);
                end
            end
            PH_AUTH: begin
                if (b == CH_HASH) begin
                    st.hash_seen = 1'b1;
                end
                if (b == CH_SLASH) begin
                    st.path_seen = 1'b1;
                    st.phase     = PH_PATH;
                    m0           = mk_res(b, PART_PATH);
                end else if (b == CH_QUEST) begin
                    st.path_seen  = 1'b1;
                    st.query_seen = 1'b1;
                    st.phase      = PH_QUERY;
                    m0            = mk_res(CH_SLASH, PART_PATH);
                    m1            = mk_res(b, PART_SEP);
                    two           = 1'b1;
                end else begin
                    st.authority_nonempty = 1'b1;
                    if (b == CH_AT) begin
                        st.at_in_authority = 1'b1;
                    end
                    m0 = mk_res(b, PART_AUTH);
                end
            end
            PH_PATH: begin
                if (b == CH_HASH) begin
                    st.hash_seen = 1'b1;
                end
                if (b == CH_QUEST) begin
                    st.query_seen = 1'b1;
                    st.phase      = PH_QUERY;
                    m0            = mk_res(b, PART_SEP);
                end else begin
                    m0 = mk_res(b, PART_PATH);
                end
            end
            PH_QUERY: begin
                if (b == CH_HASH) begin
                    st.hash_seen = 1'b1;
                end
                m0 = mk_res(b, PART_QUERY);
            end
        endcase
    end

    always_comb begin
        slash = i_item.last_byte && (st.phase == PH_AUTH) && !st.path_seen;
        priority if (st.phase == PH_SCHEME) begin
            stat = ST_NO_SCHEME;
        end else if (st.scheme_bad) begin
            stat = ST_BAD_SCHEME;
        end else if (!st.authority_nonempty) begin
            stat = ST_NO_AUTH;
        end else if (st.at_in_authority) begin
            stat = ST_USER_INFO;
        end else if (st.hash_seen) begin
            stat = ST_FRAGMENT;
        end else begin
            stat = ST_OK;
        end
        fin            = mk_res(8'h00, PART_END);
        fin.end_of_url = 1'b1;
        fin.status     = stat;
        fin.has_query  = st.query_seen;
        st_fin         = i_item.last_byte ? PSTATE_RESET : st;
    end

    assign o_st     = st_fin;
    assign o_res[0] = m0;
    assign o_res[1] = two ? m1 : (slash ? mk_res(CH_SLASH, PART_PATH) : fin);
    assign o_res[2] = fin;
    assign o_cnt    = 2'd1 + {1'b0, two} + {1'b0, slash} + {1'b0, i_item.last_byte};

endmodule

// ===== sv/hus_obuf.sv =====
// hus_obuf: result register holding up to three beats of one byte
// depends on hus_pkg
`timescale 1ns / 1ps

module hus_obuf (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  hus_pkg::t_res [hus_pkg::RES_SLOTS-1:0] i_res,
    input  logic [1:0]                             i_cnt,
    output logic                                   o_can_load,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output hus_pkg::t_res                          o_result
);
    import hus_pkg::*;

    t_res [RES_SLOTS-1:0] r_res;
    logic [1:0]           r_cnt;
    logic [1:0]           r_idx;
    logic                 take;

    assign o_valid    = (r_idx < r_cnt);
    assign take       = o_valid && !i_stall;
    assign o_can_load = !o_valid || (take && (r_idx == r_cnt - 2'd1));
    assign o_result   = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/http_url_splitter.sv =====
// http_url_splitter: tags url bytes as scheme, separator, authority, path, query
// depends on hus_pkg, hus_step, hus_obuf
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------
//  in      | i_valid | o_stall | i_item   (hus_pkg::t_item)
//  out     | o_valid | i_stall | o_result (hus_pkg::t_res)
//
// one byte a cycle when each byte gives one beat and i_stall is low; a byte
// giving two or three beats keeps the next byte in the input register until
// its last beat leaves; each byte passes the input then the result register
// reset clears parse state and both registers' valid state; no clearing pass
// o_stall rises only when the input register is full and the result register
// still has beats of the previous byte left after this cycle
`timescale 1ns / 1ps

module http_url_splitter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hus_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output hus_pkg::t_res   o_result
);
    import hus_pkg::*;

    logic                 r_in_v;
    t_item                r_in;
    t_pstate              r_st;
    t_pstate              n_st;
    t_res [RES_SLOTS-1:0] res;
    logic [1:0]           cnt;
    logic                 can_load;
    logic                 load;

    assign load    = r_in_v && can_load;
    assign o_stall = r_in_v && !can_load;

    hus_step u_step (
        .i_st   (r_st),
        .i_item (r_in),
        .o_st   (n_st),
        .o_res  (res),
        .o_cnt  (cnt)
    );

    hus_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (res),
        .i_cnt      (cnt),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_st   <= PSTATE_RESET;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_v <= 1'b1;
            end else if (load) begin
                r_in_v <= 1'b0;
            end
            if (load) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
    end

endmodule

// ===== sv/hus_checker.sv =====
// hus_checker: port-level checks on the url splitter, bound to the top level
// depends on hus_pkg and http_url_splitter
`timescale 1ns / 1ps

module hus_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input hus_pkg::t_res  o_result
);
    import hus_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled output beat changed");

    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.end_of_url |->
            o_result.part == PART_END && o_result.byte_out == 8'h00 &&
            o_result.status <= ST_FRAGMENT)
        else $error("malformed end beat");

    a_data_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_url |->
            o_result.part != PART_END && o_result.status == ST_OK &&
            !o_result.has_query)
        else $error("data beat carries status");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind http_url_splitter hus_checker u_hus_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
